@@ design/urs_pkg.sv @@
`timescale 1ns / 1ps

package urs_pkg;

   // Field widths
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned CAPTURE_W = 32;
   localparam int unsigned TICKS_W   = 16;
   localparam int unsigned DIST_W    = 9;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_TIMEOUT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_GAP   = 1'd1;
   localparam logic [TICKS_W-1:0]     TICKS_RESET      = 16'd100;

   // Distance conversion: echo time / 58, clamped to 400 cm
   localparam int unsigned DIST_MAX     = 400;
   localparam int unsigned DIST_DIVISOR = 58;
   localparam int unsigned CLAMP_LIMIT  = (DIST_MAX + 1) * DIST_DIVISOR;
   localparam int unsigned SMALL_W      = 15;
   localparam int unsigned RECIP_SHIFT  = SMALL_W + 6;
   localparam int unsigned RECIP_58     =
      ((1 << RECIP_SHIFT) + DIST_DIVISOR - 1) / DIST_DIVISOR;
   localparam int unsigned RECIP_W      = 16;
   localparam logic [CAPTURE_W-1:0] HIGH_HALF_MASK = 32'hFFFF_0000;

   // One result item
   typedef struct packed {
      logic              trigger_pulse;
      logic              capture_falling_edge;
      logic              echo_timeout;
      logic              sample_done;
      logic [DIST_W-1:0] sample_distance;
      logic [DIST_W-1:0] read_value;
   } urs_result_type;

endpackage

@@ design/urs_if.sv @@
`timescale 1ns / 1ps

// Request channel: one item per transfer
interface urs_req_if import urs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [CAPTURE_W-1:0] capture;

   modport source (output valid, output mode, output capture, input ready);
   modport sink   (input valid, input mode, input capture, output ready);
endinterface

// Response channel: one result per transfer
interface urs_rsp_if import urs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              trigger_pulse;
   logic              capture_falling_edge;
   logic              echo_timeout;
   logic              sample_done;
   logic [DIST_W-1:0] sample_distance;
   logic [DIST_W-1:0] read_value;

   modport source (output valid, output trigger_pulse, output capture_falling_edge,
                   output echo_timeout, output sample_done, output sample_distance,
                   output read_value, input ready);
   modport sink   (input valid, input trigger_pulse, input capture_falling_edge,
                   input echo_timeout, input sample_done, input sample_distance,
                   input read_value, output ready);
endinterface

@@ design/urs_distance.sv @@
`timescale 1ns / 1ps

// Echo time to distance in cm: wrap difference, fold negative small values,
// clamp, then divide by 58 through a reciprocal multiply.
module urs_distance import urs_pkg::*; (
   input  logic [CAPTURE_W-1:0] echo_start,
   input  logic [CAPTURE_W-1:0] echo_end,
   output logic [DIST_W-1:0]    distance
);

   logic [CAPTURE_W-1:0]         diff;
   logic [CAPTURE_W-1:0]         folded;
   logic [RECIP_W-1:0]           recip;
   logic [SMALL_W+RECIP_W-1:0]   product;

   assign diff  = echo_end - echo_start;
   assign recip = RECIP_W'(RECIP_58);

   // top half all ones: keep only the low half
   always_comb begin
      if ((diff & HIGH_HALF_MASK) == HIGH_HALF_MASK) begin
         folded = diff & ~HIGH_HALF_MASK;
      end else begin
         folded = diff;
      end
   end

   // below the clamp limit the value fits SMALL_W bits, exact quotient
   assign product = folded[SMALL_W-1:0] * recip;

   always_comb begin
      if (folded >= CAPTURE_W'(CLAMP_LIMIT)) begin
         distance = DIST_W'(DIST_MAX);
      end else begin
         distance = product[RECIP_SHIFT +: DIST_W];
      end
   end

endmodule

@@ design/urs_average.sv @@
`timescale 1ns / 1ps

// Block total divided by the sample count, exact for any count via a
// rounded-up reciprocal.
module urs_average import urs_pkg::*; #(
   parameter int unsigned SAMPLES = 16
) (
   input  logic [$clog2(DIST_MAX*SAMPLES+1)-1:0] total,
   output logic [DIST_W-1:0]                      average
);

   localparam int unsigned SUM_W = $clog2(DIST_MAX * SAMPLES + 1);
   localparam int unsigned SHIFT = SUM_W + $clog2(SAMPLES);
   localparam int unsigned RECIP = ((1 << SHIFT) + SAMPLES - 1) / SAMPLES;

   logic [SUM_W:0]       recip;
   logic [2*SUM_W:0]     product;

   assign recip   = (SUM_W+1)'(RECIP);
   assign product = total * recip;
   assign average = product[SHIFT +: DIST_W];

endmodule

@@ design/ultrasonic_ranger_sequencer_core.sv @@
`timescale 1ns / 1ps

// Ultrasonic ranging sequencer. Takes one request per clock unless the response
// side stalls: ticks step the trigger / echo-wait / sample / gap phases, echo
// captures load the timer stamps, and a read returns and clears the latest
// block average. Every request gives exactly one response, passing through an
// input register, then the phase update and distance math, then the response
// register; throughput is one item per cycle, limited only by the response
// side's ready. Configuration writes are taken at any edge with csr_write_en
// high and must only be issued while no request is in flight.
module ultrasonic_ranger_sequencer_core import urs_pkg::*; #(
   parameter int unsigned SAMPLES_PER_AVERAGE = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   urs_req_if.sink                req_port,
   urs_rsp_if.source              rsp_port,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TICKS_W-1:0]     csr_write_data
);

   localparam int unsigned SUM_W = $clog2(DIST_MAX * SAMPLES_PER_AVERAGE + 1);
   localparam int unsigned CNT_W = $clog2(SAMPLES_PER_AVERAGE);

   // Phase codes
   localparam logic [2:0] PH_UNKNOWN   = 3'd0;
   localparam logic [2:0] PH_TRIG      = 3'd1;
   localparam logic [2:0] PH_WAIT_ECHO = 3'd2;
   localparam logic [2:0] PH_SAMPLE    = 3'd3;
   localparam logic [2:0] PH_GAP       = 3'd4;

   // Configuration
   logic [TICKS_W-1:0] echo_timeout_ff;
   logic [TICKS_W-1:0] sample_gap_ff;

   // Input stage
   logic                 in_valid_ff;
   logic [MODE_W-1:0]    in_mode_ff;
   logic [CAPTURE_W-1:0] in_capture_ff;

   // Sequencer state
   logic [2:0]           phase_ff,       phase_in;
   logic [TICKS_W-1:0]   wait_count_ff,  wait_count_in;
   logic [CAPTURE_W-1:0] echo_start_ff,  echo_start_in;
   logic [CAPTURE_W-1:0] echo_end_ff,    echo_end_in;
   logic                 echo_ready_ff,  echo_ready_in;
   logic [SUM_W-1:0]     sample_sum_ff,  sample_sum_in;
   logic [CNT_W-1:0]     sample_cnt_ff,  sample_cnt_in;
   logic [SUM_W-1:0]     block_total_ff, block_total_in;
   logic                 edge_fall_ff,   edge_fall_in;

   // Output stage
   logic                 out_valid_ff;
   urs_result_type       result_ff, result_in;

   logic                 advance;
   logic [DIST_W-1:0]    distance;
   logic [DIST_W-1:0]    average;
   logic [SUM_W-1:0]     sum_plus;

   urs_distance u_distance (
      .echo_start (echo_start_ff),
      .echo_end   (echo_end_ff),
      .distance   (distance)
   );

   urs_average #(.SAMPLES(SAMPLES_PER_AVERAGE)) u_average (
      .total   (block_total_ff),
      .average (average)
   );

   // Handshake: the input register moves on when the output register frees
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;

   assign sum_plus = sample_sum_ff + SUM_W'(distance);

   // Per-item state update and result
   always_comb begin
      phase_in       = phase_ff;
      wait_count_in  = wait_count_ff;
      echo_start_in  = echo_start_ff;
      echo_end_in    = echo_end_ff;
      echo_ready_in  = echo_ready_ff;
      sample_sum_in  = sample_sum_ff;
      sample_cnt_in  = sample_cnt_ff;
      block_total_in = block_total_ff;
      edge_fall_in   = edge_fall_ff;
      result_in      = '0;

      case (in_mode_ff)
         MODE_START: begin
            echo_start_in = in_capture_ff;
            edge_fall_in  = 1'b1;
         end
         MODE_END: begin
            echo_end_in   = in_capture_ff;
            echo_ready_in = 1'b1;
         end
         MODE_READ: begin
            result_in.read_value = average;
            block_total_in       = '0;
         end
         default: begin
            case (phase_ff)
               PH_TRIG: begin
                  result_in.trigger_pulse = 1'b1;
                  edge_fall_in            = 1'b0;
                  wait_count_in           = '0;
                  phase_in                = PH_WAIT_ECHO;
               end
               PH_WAIT_ECHO: begin
                  if (echo_ready_ff) begin
                     wait_count_in = '0;
                     phase_in      = PH_SAMPLE;
                  end else if (wait_count_ff > echo_timeout_ff) begin
                     wait_count_in          = '0;
                     result_in.echo_timeout = 1'b1;
                     phase_in               = PH_TRIG;
                  end else if (wait_count_ff != '1) begin
                     wait_count_in = wait_count_ff + 1'b1;
                  end
               end
               PH_SAMPLE: begin
                  result_in.sample_done     = 1'b1;
                  result_in.sample_distance = distance;
                  echo_ready_in             = 1'b0;
                  wait_count_in             = '0;
                  phase_in                  = PH_GAP;
                  if (sample_cnt_ff == CNT_W'(SAMPLES_PER_AVERAGE - 1)) begin
                     block_total_in = sum_plus;
                     sample_sum_in  = '0;
                     sample_cnt_in  = '0;
                  end else begin
                     sample_sum_in  = sum_plus;
                     sample_cnt_in  = sample_cnt_ff + 1'b1;
                  end
               end
               PH_GAP: begin
                  if (wait_count_ff > sample_gap_ff) begin
                     wait_count_in = '0;
                     phase_in      = PH_TRIG;
                  end else if (wait_count_ff != '1) begin
                     wait_count_in = wait_count_ff + 1'b1;
                  end
               end
               default: begin
                  wait_count_in = '0;
                  phase_in      = PH_WAIT_ECHO;
               end
            endcase
         end
      endcase

      result_in.capture_falling_edge = edge_fall_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_timeout_ff <= TICKS_RESET;
         sample_gap_ff   <= TICKS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ECHO_TIMEOUT: echo_timeout_ff <= csr_write_data;
            CSR_SAMPLE_GAP:   sample_gap_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         in_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_mode_ff    <= req_port.mode;
         in_capture_ff <= req_port.capture;
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_UNKNOWN;
         wait_count_ff  <= '0;
         echo_start_ff  <= '0;
         echo_end_ff    <= '0;
         echo_ready_ff  <= 1'b0;
         sample_sum_ff  <= '0;
         sample_cnt_ff  <= '0;
         block_total_ff <= '0;
         edge_fall_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         wait_count_ff  <= wait_count_in;
         echo_start_ff  <= echo_start_in;
         echo_end_ff    <= echo_end_in;
         echo_ready_ff  <= echo_ready_in;
         sample_sum_ff  <= sample_sum_in;
         sample_cnt_ff  <= sample_cnt_in;
         block_total_ff <= block_total_in;
         edge_fall_ff   <= edge_fall_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_port.valid                = out_valid_ff;
   assign rsp_port.trigger_pulse        = result_ff.trigger_pulse;
   assign rsp_port.capture_falling_edge = result_ff.capture_falling_edge;
   assign rsp_port.echo_timeout         = result_ff.echo_timeout;
   assign rsp_port.sample_done          = result_ff.sample_done;
   assign rsp_port.sample_distance      = result_ff.sample_distance;
   assign rsp_port.read_value           = result_ff.read_value;

endmodule

@@ design/urs_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks on the ranging sequencer's responses
module urs_checker import urs_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              trigger_pulse,
   input logic              capture_falling_edge,
   input logic              echo_timeout,
   input logic              sample_done,
   input logic [DIST_W-1:0] sample_distance,
   input logic [DIST_W-1:0] read_value
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_distance)
         && $stable(read_value) && $stable(trigger_pulse))
      else $error("stalled response changed");

   // one step does at most one thing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({trigger_pulse, echo_timeout, sample_done,
                              read_value != '0}))
      else $error("conflicting response flags");

   // a trigger always re-arms the rising edge capture
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && trigger_pulse |-> !capture_falling_edge)
      else $error("trigger left falling edge selected");

   // distance only with a sample, and within range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (sample_done || sample_distance == '0)
         && sample_distance <= DIST_W'(DIST_MAX) && read_value <= DIST_W'(DIST_MAX))
      else $error("distance out of place or out of range");

endmodule

bind ultrasonic_ranger_sequencer_core urs_checker u_urs_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_port.valid),
   .rsp_ready            (rsp_port.ready),
   .trigger_pulse        (rsp_port.trigger_pulse),
   .capture_falling_edge (rsp_port.capture_falling_edge),
   .echo_timeout         (rsp_port.echo_timeout),
   .sample_done          (rsp_port.sample_done),
   .sample_distance      (rsp_port.sample_distance),
   .read_value           (rsp_port.read_value)
);

@@ tb/ultrasonic_ranger_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

module ultrasonic_ranger_sequencer_core_tb import urs_pkg::*; ;

   localparam int unsigned AVG_COUNT   = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;

   // Sequencer phases as the predictor tracks them
   typedef enum logic [2:0] {
      ST_RESET     = 3'd0,
      ST_TRIGGER   = 3'd1,
      ST_ECHO_WAIT = 3'd2,
      ST_SAMPLE    = 3'd3,
      ST_GAP       = 3'd4
   } stage_type;

   // Ranging predictor plus the queue of responses it expects
   class ranger_scoreboard;
      logic [TICKS_W-1:0]   echo_timeout_ticks;
      logic [TICKS_W-1:0]   sample_gap_ticks;
      stage_type            stage;
      logic [TICKS_W-1:0]   wait_ticks;
      logic [CAPTURE_W-1:0] echo_start;
      logic [CAPTURE_W-1:0] echo_end;
      bit                   echo_seen;
      int unsigned          dist_sum;
      int unsigned          dist_count;
      logic [DIST_W-1:0]    average;
      bit                   falling;
      urs_result_type       expected_q[$];
      int unsigned          errors;

      function new();
         echo_timeout_ticks = TICKS_RESET;
         sample_gap_ticks   = TICKS_RESET;
         stage              = ST_RESET;
         wait_ticks         = '0;
         echo_start         = '0;
         echo_end           = '0;
         echo_seen          = 1'b0;
         dist_sum           = 0;
         dist_count         = 0;
         average            = '0;
         falling            = 1'b0;
         errors             = 0;
      endfunction

      function void set_ticks(logic [TICKS_W-1:0] timeout, logic [TICKS_W-1:0] gap);
         echo_timeout_ticks = timeout;
         sample_gap_ticks   = gap;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // True once the elapsed ticks exceed the limit; the count saturates
      function bit wait_over(logic [TICKS_W-1:0] limit);
         if (wait_ticks > limit) begin
            wait_ticks = '0;
            return 1'b1;
         end
         if (wait_ticks != '1)
            wait_ticks++;
         return 1'b0;
      endfunction

      // Echo span to centimeters: top-half-all-ones spans fold to 16 bits
      function logic [DIST_W-1:0] range_cm(logic [CAPTURE_W-1:0] t0, logic [CAPTURE_W-1:0] t1);
         logic [CAPTURE_W-1:0] span;
         logic [CAPTURE_W-1:0] cm;
         span = t1 - t0;
         if ((span & HIGH_HALF_MASK) == HIGH_HALF_MASK)
            span = span & ~HIGH_HALF_MASK;
         cm = span / DIST_DIVISOR;
         if (cm > DIST_MAX)
            cm = DIST_MAX;
         return cm[DIST_W-1:0];
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [CAPTURE_W-1:0] capture);
         urs_result_type r;
         int unsigned    mean;
         r = '0;
         case (mode)
            MODE_START: begin
               echo_start = capture;
               falling    = 1'b1;
            end
            MODE_END: begin
               echo_end  = capture;
               echo_seen = 1'b1;
            end
            MODE_READ: begin
               r.read_value = average;
               average      = '0;
            end
            default: begin
               case (stage)
                  ST_TRIGGER: begin
                     r.trigger_pulse = 1'b1;
                     falling         = 1'b0;
                     wait_ticks      = '0;
                     stage           = ST_ECHO_WAIT;
                  end
                  ST_ECHO_WAIT: begin
                     if (echo_seen) begin
                        wait_ticks = '0;
                        stage      = ST_SAMPLE;
                     end else if (wait_over(echo_timeout_ticks)) begin
                        r.echo_timeout = 1'b1;
                        stage          = ST_TRIGGER;
                     end
                  end
                  ST_SAMPLE: begin
                     r.sample_done     = 1'b1;
                     r.sample_distance = range_cm(echo_start, echo_end);
                     dist_sum          += r.sample_distance;
                     dist_count++;
                     echo_seen         = 1'b0;
                     wait_ticks        = '0;
                     stage             = ST_GAP;
                     if (dist_count >= AVG_COUNT) begin
                        mean       = dist_sum / AVG_COUNT;
                        average    = mean[DIST_W-1:0];
                        dist_sum   = 0;
                        dist_count = 0;
                     end
                  end
                  ST_GAP: begin
                     if (wait_over(sample_gap_ticks))
                        stage = ST_TRIGGER;
                  end
                  // reset phase: first tick only moves to the echo wait
                  default: begin
                     wait_ticks = '0;
                     stage      = ST_ECHO_WAIT;
                  end
               endcase
            end
         endcase
         r.capture_falling_edge = falling;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string field, logic [DIST_W-1:0] want,
                                  logic [DIST_W-1:0] got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_response(urs_result_type got);
         urs_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual %h", $time, got);
            return;
         end
         want = expected_q.pop_front();
         compare_field("trigger_pulse", DIST_W'(want.trigger_pulse),
                       DIST_W'(got.trigger_pulse));
         compare_field("capture_falling_edge", DIST_W'(want.capture_falling_edge),
                       DIST_W'(got.capture_falling_edge));
         compare_field("echo_timeout", DIST_W'(want.echo_timeout),
                       DIST_W'(got.echo_timeout));
         compare_field("sample_done", DIST_W'(want.sample_done),
                       DIST_W'(got.sample_done));
         compare_field("sample_distance", want.sample_distance, got.sample_distance);
         compare_field("read_value", want.read_value, got.read_value);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [TICKS_W-1:0]     csr_write_data;

   urs_req_if req_bus ();
   urs_rsp_if rsp_bus ();

   ranger_scoreboard board;
   bit               idling;
   int unsigned      sent;
   int unsigned      cycles;
   int unsigned      stall_left;

   ultrasonic_ranger_sequencer_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_port       (req_bus),
      .rsp_port       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("ultrasonic_ranger_sequencer_core regression: fail");
         $finish;
      end
   end

   // Response side: random stall bursts, check every transfer
   initial begin
      rsp_bus.ready = 1'b1;
      stall_left    = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
               urs_result_type got;
               got.trigger_pulse        = rsp_bus.trigger_pulse;
               got.capture_falling_edge = rsp_bus.capture_falling_edge;
               got.echo_timeout         = rsp_bus.echo_timeout;
               got.sample_done          = rsp_bus.sample_done;
               got.sample_distance      = rsp_bus.sample_distance;
               got.read_value           = rsp_bus.read_value;
               board.check_response(got);
            end
            if (stall_left != 0) begin
               stall_left--;
               if (stall_left == 0)
                  rsp_bus.ready <= 1'b1;
            end else if (idling && $urandom_range(0, 7) == 0) begin
               stall_left    = $urandom_range(1, 9);
               rsp_bus.ready <= 1'b0;
            end
         end
      end
   end

   // One request transfer, with an optional idle burst in front
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [CAPTURE_W-1:0] capture);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.capture <= capture;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(mode, capture);
      sent++;
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_request(MODE_TICK, $urandom());
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic program_ticks(input logic [TICKS_W-1:0] timeout,
                                input logic [TICKS_W-1:0] gap);
      drain();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_ECHO_TIMEOUT;
      csr_write_data <= timeout;
      @(posedge clock);
      csr_index      <= CSR_SAMPLE_GAP;
      csr_write_data <= gap;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      board.set_ticks(timeout, gap);
   endtask

   // Echo durations aimed at the folding and clamping boundaries
   function automatic logic [CAPTURE_W-1:0] echo_span();
      logic [CAPTURE_W-1:0] span;
      case ($urandom_range(0, 7))
         0: span = $urandom_range(0, DIST_DIVISOR - 1);
         1: span = DIST_DIVISOR * $urandom_range(1, DIST_MAX) + $urandom_range(0, 2) - 1;
         2: span = $urandom_range(0, CLAMP_LIMIT - 1);
         3: span = CLAMP_LIMIT - DIST_DIVISOR + $urandom_range(0, 2 * DIST_DIVISOR);
         4: span = $urandom();
         5: span = HIGH_HALF_MASK | $urandom_range(0, 65535);
         6: span = 32'hFFFE_0000 | $urandom_range(0, 65535);
         default: span = $urandom_range(0, 65535);
      endcase
      return span;
   endfunction

   // Well-formed ranging: reach the echo wait, then start and end captures
   task automatic echo_cycle();
      int unsigned          guard;
      logic [CAPTURE_W-1:0] t0;
      guard = 0;
      while (board.stage != ST_ECHO_WAIT && guard < 200) begin
         send_request(MODE_TICK, $urandom());
         guard++;
      end
      if ($urandom_range(0, 3) == 0)
         send_ticks($urandom_range(1, 4));
      t0 = $urandom();
      send_request(MODE_START, t0);
      if ($urandom_range(0, 5) == 0)
         send_ticks($urandom_range(1, 3));
      send_request(MODE_END, t0 + echo_span());
      send_ticks($urandom_range(2, 3));
   endtask

   task automatic random_traffic(input int unsigned budget);
      int unsigned          first;
      int unsigned          pick;
      logic [MODE_W-1:0]    mode;
      first = sent;
      while (sent - first < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            echo_cycle();
         end else if (pick < 75) begin
            send_ticks($urandom_range(1, 12));
         end else if (pick < 85) begin
            send_request(MODE_READ, $urandom());
         end else begin
            mode = MODE_W'($urandom_range(0, 3));
            send_request(mode, $urandom());
         end
      end
   endtask

   // Main sequence
   initial begin
      board          = new();
      idling         = 1'b1;
      sent           = 0;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_ECHO_TIMEOUT;
      csr_write_data = '0;
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_TICK;
      req_bus.capture = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: leave the reset phase, read an empty average,
      // then a full-range echo that folds and clamps
      send_request(MODE_TICK, 32'h0000_0000);
      send_request(MODE_READ, 32'hFFFF_FFFF);
      send_request(MODE_START, 32'h0000_0000);
      send_request(MODE_END, 32'hFFFF_FFFF);
      send_ticks(2);

      // Short waits: echo end arriving during the gap is kept for the next wait
      program_ticks(16'd3, 16'd2);
      send_request(MODE_END, 32'h0000_0100);
      send_ticks(4);
      send_ticks(3);
      send_ticks(4);
      // trigger, then no echo until the timeout
      send_ticks(6);
      send_request(MODE_READ, 32'h5A5A_A5A5);

      program_ticks(16'd0, 16'd0);
      random_traffic(350);
      program_ticks(16'hFFFF, 16'hFFFF);
      random_traffic(150);

      program_ticks(16'd1, 16'd1);
      random_traffic(350);
      program_ticks(TICKS_W'($urandom_range(2, 12)), TICKS_W'($urandom_range(2, 12)));
      random_traffic(400);
      program_ticks(16'hFFFF, 16'd0);
      random_traffic(200);
      program_ticks(TICKS_RESET, TICKS_RESET);
      random_traffic(300);

      // Final stretch at full rate on both sides
      program_ticks(TICKS_W'($urandom_range(0, 20)), TICKS_W'($urandom_range(0, 20)));
      idling = 1'b0;
      random_traffic(200);

      drain();
      repeat (4) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("ultrasonic_ranger_sequencer_core regression: pass");
      else
         $display("ultrasonic_ranger_sequencer_core regression: fail");
      $finish;
   end

endmodule
